/* src/floppy_read_channel_controller_macros.svh */
// Assertion helpers for the floppy read channel
`ifndef FLOPPY_READ_CHANNEL_CONTROLLER_MACROS_SVH
`define FLOPPY_READ_CHANNEL_CONTROLLER_MACROS_SVH

// same-cycle implication
`define FRCC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FRCC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/frcc_pkg.sv */
package frcc_pkg;

    localparam logic [2:0] SW_PHASE_LAST = 3'd3;
    localparam logic [2:0] SW_POWER      = 3'd4;
    localparam logic [2:0] SW_SELECT     = 3'd5;
    localparam logic [2:0] SW_SHIFT_LOAD = 3'd6;
    localparam logic [2:0] SW_READ_WRITE = 3'd7;

    localparam logic [0:0] CFG_WP_FIRST  = 1'b0;
    localparam logic [0:0] CFG_WP_SECOND = 1'b1;

    typedef struct packed {
        logic        action;
        logic [2:0]  switch_index;
        logic        switch_on;
        logic        is_write;
        logic [7:0]  elapsed_cycles;
        logic        load_drive;
        logic [5:0]  load_track;
        logic [12:0] load_position;
        logic [7:0]  load_value;
    } t_in;

    typedef struct packed {
        logic [7:0]  read_data;
        logic [6:0]  head_half_track;
        logic [12:0] head_position;
        logic        selected_drive;
    } t_out;

    typedef struct packed {
        logic        is_load;
        logic        load_ok;
        logic [2:0]  sw;
        logic        on;
        logic        rd_req;
        logic [7:0]  cycles;
        logic        ld;
        logic [5:0]  lt;
        logic [12:0] lp;
        logic [7:0]  value;
    } t_cmd;

endpackage

/* src/floppy_read_channel_controller.sv */
// Flow: a load item, or a switch item that leaves the motor off, goes from APPLY to DONE;
// a powered switch item also runs the RUN bit-step loop ((residue + elapsed)/4 bit steps,
// up to 64) and passes through FETCH for each surface byte fetch.
// Throughput: one item at a time in the back sequencer, bounded by the bit-step loop
// and the single surface RAM read port; a two-entry queue takes items meanwhile.
// Reset: synchronous, active low; clears all head, latch and mode state; the surface
// RAM is not cleared and reads undefined until written.
`include "floppy_read_channel_controller_macros.svh"

module floppy_read_channel_controller #(
    parameter int TRACKS         = 35,
    parameter int TRACK_BYTES    = 6656,
    parameter int CYCLES_PER_BIT = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  frcc_pkg::t_in  i_in,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output frcc_pkg::t_out o_out,
    input  logic           i_cfg_we,
    input  logic [0:0]     i_cfg_index,
    input  logic           i_cfg_wdata
);

    logic           r_wp_first;
    logic           r_wp_second;
    logic           w_q_valid;
    logic           w_q_pop;
    frcc_pkg::t_cmd w_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp_first  <= 1'b0;
            r_wp_second <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                frcc_pkg::CFG_WP_FIRST:  r_wp_first  <= i_cfg_wdata;
                frcc_pkg::CFG_WP_SECOND: r_wp_second <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    frcc_front #(
        .TRACKS      (TRACKS),
        .TRACK_BYTES (TRACK_BYTES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .o_q_valid  (w_q_valid),
        .i_q_pop    (w_q_pop),
        .o_q        (w_q)
    );

    frcc_back #(
        .TRACKS         (TRACKS),
        .TRACK_BYTES    (TRACK_BYTES),
        .CYCLES_PER_BIT (CYCLES_PER_BIT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wp_first  (r_wp_first),
        .i_wp_second (r_wp_second),
        .i_q_valid   (w_q_valid),
        .o_q_pop     (w_q_pop),
        .i_q         (w_q),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    `FRCC_ASSERT_NOW(a_ht_range, o_out_valid, 32'(o_out.head_half_track) < 2 * TRACKS, "head out of range")
    `FRCC_ASSERT_NOW(a_pos_range, o_out_valid, 32'(o_out.head_position) < TRACK_BYTES, "position out of range")
    `FRCC_ASSERT_NEXT(a_pop_busy, w_q_pop, !w_q_pop, "back took two items back to back")

endmodule

/* src/frcc_ram.sv */
module frcc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/frcc_front.sv */
module frcc_front #(
    parameter int TRACKS      = 35,
    parameter int TRACK_BYTES = 6656
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  frcc_pkg::t_in  i_in,
    output logic           o_q_valid,
    input  logic           i_q_pop,
    output frcc_pkg::t_cmd o_q
);

    frcc_pkg::t_cmd r_q [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    frcc_pkg::t_cmd w_cmd;
    logic           w_push;
    logic           w_pop;

    always_comb begin
        w_cmd.is_load = i_in.action;
        w_cmd.load_ok = (32'(i_in.load_track) < TRACKS) && (32'(i_in.load_position) < TRACK_BYTES);
        w_cmd.sw      = i_in.switch_index;
        w_cmd.on      = i_in.switch_on;
        w_cmd.rd_req  = !i_in.is_write && !i_in.switch_on;
        w_cmd.cycles  = i_in.elapsed_cycles;
        w_cmd.ld      = i_in.load_drive;
        w_cmd.lt      = i_in.load_track;
        w_cmd.lp      = i_in.load_position;
        w_cmd.value   = i_in.load_value;
    end

    assign o_in_ready = (r_cnt != 2'd2);
    assign w_push     = i_in_valid && o_in_ready;
    assign w_pop      = i_q_pop && o_q_valid;
    assign o_q_valid  = (r_cnt != 2'd0);
    assign o_q        = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

endmodule

/* src/frcc_back.sv */
module frcc_back #(
    parameter int TRACKS         = 35,
    parameter int TRACK_BYTES    = 6656,
    parameter int CYCLES_PER_BIT = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wp_first,
    input  logic           i_wp_second,
    input  logic           i_q_valid,
    output logic           o_q_pop,
    input  frcc_pkg::t_cmd i_q,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output frcc_pkg::t_out o_out
);

    localparam int TRK_W  = (TRACKS > 1) ? $clog2(TRACKS) : 1;
    localparam int POS_W  = $clog2(TRACK_BYTES);
    localparam int AW     = 1 + TRK_W + POS_W;
    localparam int RES_W  = (CYCLES_PER_BIT > 1) ? $clog2(CYCLES_PER_BIT) : 1;
    localparam int ACC_W  = 9;
    localparam logic [6:0]  MAX_HT   = 7'(2 * TRACKS - 1);
    localparam logic [12:0] LAST_POS = 13'(TRACK_BYTES - 1);
    localparam logic [ACC_W-1:0] CPB = ACC_W'(CYCLES_PER_BIT);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_APPLY = 3'd1;
    localparam logic [2:0] ST_FETCH = 3'd2;
    localparam logic [2:0] ST_RUN   = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0]       r_state;
    frcc_pkg::t_cmd   r_cmd;
    logic [6:0]       r_ht    [2];
    logic [1:0]       r_phase [2];
    logic [5:0]       r_lt    [2];
    logic [12:0]      r_pos   [2];
    logic [7:0]       r_sb    [2];
    logic [2:0]       r_bc    [2];
    logic [7:0]       r_latch;
    logic [RES_W-1:0] r_res;
    logic [ACC_W-1:0] r_acc;
    logic             r_motor;
    logic             r_drive;
    logic             r_load_mode;
    logic             r_write_mode;
    logic             r_out_valid;
    frcc_pkg::t_out   r_out;

    logic             d;
    logic [1:0]       w_p;
    logic [6:0]       w_ht_n;
    logic             w_move;
    logic             w_reload;
    logic             w_motor_n;
    logic [RES_W-1:0] w_res_n;
    logic             w_step;
    logic             w_read_mode;
    logic             w_wrap;
    logic [12:0]      w_pos_n;
    logic [7:0]       w_latch_n;
    logic             w_re;
    logic [AW-1:0]    w_raddr;
    logic             w_we;
    logic [AW-1:0]    w_waddr;
    logic [7:0]       w_rdata;
    logic             w_out_free;

    assign d = r_drive;

    always_comb begin
        w_p    = r_cmd.sw[1:0];
        w_move = r_motor && r_cmd.on && (r_cmd.sw <= frcc_pkg::SW_PHASE_LAST);
        w_ht_n = r_ht[d];
        if (w_p == r_phase[d] + 2'd1) begin
            if (r_ht[d] != MAX_HT) w_ht_n = r_ht[d] + 7'd1;
        end else if (w_p == r_phase[d] + 2'd3) begin
            if (r_ht[d] != 7'd0) w_ht_n = r_ht[d] - 7'd1;
        end
        w_reload  = w_move && !w_ht_n[0];
        w_motor_n = (r_cmd.sw == frcc_pkg::SW_POWER) ? r_cmd.on : r_motor;
        w_res_n   = ((r_cmd.sw <= frcc_pkg::SW_PHASE_LAST) || (r_cmd.sw == frcc_pkg::SW_POWER))
                    ? '0 : r_res;

        w_step      = (r_acc >= CPB);
        w_read_mode = !r_write_mode && !r_load_mode;
        w_wrap      = (r_bc[d] == 3'd7);
        w_pos_n     = (r_pos[d] == LAST_POS) ? 13'd0 : r_pos[d] + 13'd1;
        w_latch_n   = r_latch;
        if (r_bc[d] == 3'd1) begin
            w_latch_n = {6'd0, 1'b1, r_sb[d][7]};
        end else if (r_bc[d] != 3'd0) begin
            w_latch_n = {r_latch[6:0], r_sb[d][7]};
        end

        w_re    = 1'b0;
        w_raddr = {d, r_lt[d][TRK_W-1:0], w_pos_n[POS_W-1:0]};
        if (r_state == ST_APPLY && !r_cmd.is_load) begin
            w_re    = w_reload;
            w_raddr = {d, w_ht_n[TRK_W:1], {POS_W{1'b0}}};
        end else if (r_state == ST_RUN) begin
            w_re = w_step && w_read_mode && w_wrap;
        end
        w_we    = (r_state == ST_APPLY) && r_cmd.is_load && r_cmd.load_ok;
        w_waddr = {r_cmd.ld, r_cmd.lt[TRK_W-1:0], r_cmd.lp[POS_W-1:0]};
    end

    frcc_ram #(
        .WIDTH (8),
        .DEPTH (2 ** AW)
    ) u_surface (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (r_cmd.value),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign o_q_pop    = (r_state == ST_IDLE) && i_q_valid;
    assign w_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cmd <= i_q;
        end
        if (r_state == ST_DONE && w_out_free) begin
            r_out.read_data       <= (!r_cmd.is_load && r_cmd.rd_req) ? r_latch : 8'd0;
            r_out.head_half_track <= r_ht[d];
            r_out.head_position   <= r_pos[d];
            r_out.selected_drive  <= d;
        end
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_ht         <= '{default: '0};
            r_phase      <= '{default: '0};
            r_lt         <= '{default: '0};
            r_pos        <= '{default: '0};
            r_sb         <= '{default: '0};
            r_bc         <= '{default: '0};
            r_latch      <= '0;
            r_res        <= '0;
            r_acc        <= '0;
            r_motor      <= 1'b0;
            r_drive      <= 1'b0;
            r_load_mode  <= 1'b0;
            r_write_mode <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (r_state == ST_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_q_valid) r_state <= ST_APPLY;
                end
                ST_APPLY: begin
                    if (r_cmd.is_load) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_res   <= w_res_n;
                        r_motor <= w_motor_n;
                        r_acc   <= ACC_W'(w_res_n) + ACC_W'(r_cmd.cycles);
                        unique case (r_cmd.sw)
                            frcc_pkg::SW_POWER:      ;
                            frcc_pkg::SW_SELECT:     r_drive <= r_cmd.on;
                            frcc_pkg::SW_SHIFT_LOAD: r_load_mode <= r_cmd.on;
                            frcc_pkg::SW_READ_WRITE: begin
                                r_write_mode <= r_cmd.on;
                                r_latch      <= 8'd0;
                            end
                            default: begin
                                if (w_move) begin
                                    r_ht[d]    <= w_ht_n;
                                    r_phase[d] <= w_p;
                                end
                                if (w_reload) begin
                                    r_lt[d]  <= w_ht_n[6:1];
                                    r_pos[d] <= 13'd0;
                                    r_bc[d]  <= 3'd0;
                                end
                            end
                        endcase
                        if (w_reload) begin
                            r_state <= ST_FETCH;
                        end else if (w_motor_n) begin
                            r_state <= ST_RUN;
                        end else begin
                            r_state <= ST_DONE;
                        end
                    end
                end
                ST_FETCH: begin
                    r_sb[d] <= w_rdata;
                    r_state <= r_motor ? ST_RUN : ST_DONE;
                end
                ST_RUN: begin
                    if (w_step) begin
                        r_acc <= r_acc - CPB;
                        if (w_read_mode) begin
                            r_latch <= w_latch_n;
                            r_sb[d] <= {r_sb[d][6:0], 1'b0};
                            r_bc[d] <= r_bc[d] + 3'd1;
                            if (w_wrap) begin
                                r_pos[d] <= w_pos_n;
                                r_state  <= ST_FETCH;
                            end
                        end else if (!r_write_mode) begin
                            r_latch <= {(d ? i_wp_second : i_wp_first), 7'd0};
                        end
                    end else begin
                        r_res   <= r_acc[RES_W-1:0];
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (w_out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
